/* rtl/pnpa_pkg.sv */
// shared types and constants for the poisson noise pixel adder
package pnpa_pkg;

   // field widths of the stream payloads
   localparam int unsigned PixelWidth = 32;
   localparam int unsigned DrawWidth  = 32;
   localparam int unsigned OutWidth   = 48;
   localparam int unsigned CountWidth = 9;
   localparam int unsigned ReqWidth   = 64;
   localparam int unsigned RspWidth   = 64;

   // register widths
   localparam int unsigned GainWidth  = 24;
   localparam int unsigned MeanWidth  = 24;
   localparam int unsigned ExpWidth   = 32;
   localparam int unsigned LimitWidth = 9;

   // register port
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 32;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_EXPOSURE_GAIN = 2'd0,
      CSR_POISSON_MEAN  = 2'd1,
      CSR_EXP_NEG_MEAN  = 2'd2,
      CSR_BIN_LIMIT     = 2'd3
   } csr_index_type;

   // reset values of the registers
   localparam logic [GainWidth-1:0]  GainReset  = 24'd256;
   localparam logic [MeanWidth-1:0]  MeanReset  = 24'd655360;
   localparam logic [ExpWidth-1:0]   ExpReset   = 32'd194992;
   localparam logic [LimitWidth-1:0] LimitReset = 9'd100;

   // sequencer states, one-hot
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SCALE = 7'b0000010,
      ST_ACC   = 7'b0000100,
      ST_MUL1  = 7'b0001000,
      ST_MUL2  = 7'b0010000,
      ST_MUL3  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

endpackage

/* rtl/poisson_noise_pixel_adder.sv */
// poisson noise pixel adder: gain scaling plus inverse-cdf poisson count
// Each bin of the poisson count goes through an add/compare state (ST_ACC) and three multiply
// states (ST_MUL1 .. ST_MUL3); all products go through one 32x32 multiplier.
// A new item is taken only in ST_IDLE, once the previous one has left the search.
// The result sits in an output register, so the next item is taken while it waits.
// Reset (synchronous, active high) empties the block and loads the register defaults:
// gain 1.0, mean 10.0, e^-mean for 10.0, bin limit 100.
module poisson_noise_pixel_adder #(
   parameter int unsigned MAX_BINS = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [pnpa_pkg::ReqWidth-1:0]        req_tdata,   // pixel_value, uniform_draw
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [pnpa_pkg::RspWidth-1:0]        rsp_tdata,   // noisy_pixel, noise_count, zero pad
   // register write port
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pnpa_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [pnpa_pkg::CsrDataWidth-1:0]    csr_data
);
   import pnpa_pkg::*;

   localparam int unsigned CW = $clog2(MAX_BINS + 1);
   localparam int unsigned IW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int unsigned LW = (CW > LimitWidth) ? CW : LimitWidth;
   localparam logic [LW-1:0] MaxBinsW = LW'(MAX_BINS);

   // reciprocal rom, floor(2^32/k) for k = 1 .. MAX_BINS
   logic [32:0] recip_rom [MAX_BINS];
   for (genvar g = 0; g < MAX_BINS; g++) begin : g_recip
      localparam logic [32:0] RecipVal = 33'((64'd1 << 32) / (g + 1));
      assign recip_rom[g] = RecipVal;
   end

   // registers
   logic [GainWidth-1:0]  gain_ff;
   logic [MeanWidth-1:0]  mean_ff;
   logic [ExpWidth-1:0]   exp_ff;
   logic [LimitWidth-1:0] limit_ff;

   state_type             state_ff, state_in;
   logic [PixelWidth-1:0] pixel_ff, pixel_in;
   logic [DrawWidth-1:0]  draw_ff, draw_in;
   logic [31:0]           term_ff, term_in;
   logic [31:0]           cdf_ff, cdf_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [47:0]           scaled_ff, scaled_in;
   logic [39:0]           prod_hi_ff, prod_hi_in;
   logic [31:0]           prod_lo_ff, prod_lo_in;
   logic [32:0]           recip_ff, recip_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OutWidth-1:0]   rsp_pixel_ff, rsp_pixel_in;
   logic [CountWidth-1:0] rsp_count_ff, rsp_count_in;

   // shared multiplier
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] mul_p;

   logic [LW-1:0]  limit_w;
   logic [LW-1:0]  count_w;
   logic [32:0]    cdf_sum;
   logic [31:0]    cdf_sat;
   logic [40:0]    res_sum;
   logic [31:0]    res_sat;
   logic [48:0]    total_sum;
   logic [47:0]    total_sat;
   logic           out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspWidth - OutWidth - CountWidth){1'b0}}, rsp_count_ff, rsp_pixel_ff};

   // operand selection for the multiplier
   always_comb begin
      case (state_ff)
         ST_SCALE: begin
            mul_a = pixel_ff;
            mul_b = {8'd0, gain_ff};
         end
         ST_MUL1: begin
            mul_a = term_ff;
            mul_b = {8'd0, mean_ff};
         end
         ST_MUL2: begin
            mul_a = prod_hi_ff[31:0];
            mul_b = recip_ff[31:0];
         end
         ST_MUL3: begin
            mul_a = {24'd0, prod_hi_ff[39:32]};
            mul_b = recip_ff[31:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // search arithmetic
   assign limit_w   = (LW'(limit_ff) > MaxBinsW) ? MaxBinsW : LW'(limit_ff);
   assign count_w   = LW'(count_ff);
   assign cdf_sum   = {1'b0, cdf_ff} + {1'b0, term_ff};
   assign cdf_sat   = cdf_sum[32] ? '1 : cdf_sum[31:0];
   assign res_sum   = {1'b0, mul_p[39:0]} + 41'(prod_lo_ff);
   assign res_sat   = recip_ff[32] ? ((prod_hi_ff[39:32] != 8'd0) ? '1 : prod_hi_ff[31:0])
                                   : ((res_sum[40:32] != 9'd0) ? '1 : res_sum[31:0]);
   assign total_sum = {1'b0, scaled_ff} + (49'(count_ff) << 16);
   assign total_sat = total_sum[48] ? '1 : total_sum[47:0];
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      pixel_in     = pixel_ff;
      draw_in      = draw_ff;
      term_in      = term_ff;
      cdf_in       = cdf_ff;
      count_in     = count_ff;
      scaled_in    = scaled_ff;
      prod_hi_in   = prod_hi_ff;
      prod_lo_in   = prod_lo_ff;
      recip_in     = recip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_count_in = rsp_count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               pixel_in = req_tdata[PixelWidth-1:0];
               draw_in  = req_tdata[PixelWidth +: DrawWidth];
               term_in  = exp_ff;
               cdf_in   = '0;
               count_in = '0;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            scaled_in = mul_p[55:8];
            state_in  = ST_ACC;
         end
         ST_ACC: begin
            // stop at the bin limit or at the first cdf above the draw
            if (count_w >= limit_w) begin
               state_in = ST_DONE;
            end else if (cdf_sat > draw_ff) begin
               state_in = ST_DONE;
            end else begin
               cdf_in   = cdf_sat;
               recip_in = recip_rom[count_ff[IW-1:0]];
               count_in = count_ff + 1'b1;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            // term * mean, kept as q8.32
            prod_hi_in = mul_p[55:16];
            state_in   = ST_MUL2;
         end
         ST_MUL2: begin
            prod_lo_in = mul_p[63:32];
            state_in   = ST_MUL3;
         end
         ST_MUL3: begin
            term_in  = res_sat;
            state_in = ST_ACC;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = total_sat;
               rsp_count_in = count_w[CountWidth-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= GainReset;
         mean_ff  <= MeanReset;
         exp_ff   <= ExpReset;
         limit_ff <= LimitReset;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_EXPOSURE_GAIN: gain_ff  <= csr_data[GainWidth-1:0];
            CSR_POISSON_MEAN:  mean_ff  <= csr_data[MeanWidth-1:0];
            CSR_EXP_NEG_MEAN:  exp_ff   <= csr_data[ExpWidth-1:0];
            CSR_BIN_LIMIT:     limit_ff <= csr_data[LimitWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      pixel_ff     <= pixel_in;
      draw_ff      <= draw_in;
      term_ff      <= term_in;
      cdf_ff       <= cdf_in;
      scaled_ff    <= scaled_in;
      prod_hi_ff   <= prod_hi_in;
      prod_lo_ff   <= prod_lo_in;
      recip_ff     <= recip_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_count_ff <= rsp_count_in;
   end

   // the search never runs past the clamped bin limit
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (count_w <= limit_w))
      else $error("bin count ran past the limit");

   // a multiply step always follows a counted bin
   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL1) |-> (count_ff != '0))
      else $error("multiply step with zero count");

   // an accepted item goes straight to the gain product
   a_accept_scale: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_SCALE))
      else $error("accepted item did not start scaling");

   // a finished item always lands in the output register
   a_done_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished item not presented");

endmodule
